// ===== hw/rtl/ksa_pkg.sv =====
`default_nettype none

package ksa_pkg;

  // Fixed field widths of the stream words.
  localparam int KEY_FIELD_W = 64;
  localparam int IDX_FIELD_W = 6;
  localparam int CNT_FIELD_W = 7;
  localparam int IN_USER_W   = 2;
  localparam int OUT_DATA_W  = 16;

  typedef enum logic {
    REQ_ACQUIRE = 1'b0,
    REQ_RELEASE = 1'b1
  } ksa_req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } ksa_status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } ksa_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic lookup;  // compare the incoming key and read the stack top
    logic load;    // capture the request
    logic commit;  // update the tables and load the output register
  } ksa_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_valid;
  } ksa_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ksa_ram.sv =====
`default_nettype none

module ksa_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ksa_ctrl.sv =====
`default_nettype none

module ksa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic              out_tready,
  input  wire ksa_pkg::ksa_sts_t sts,
  output ksa_pkg::ksa_cmd_t      cmd
);

  import ksa_pkg::*;

  ksa_state_t state_r;
  ksa_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.lookup = 1'b1;
        cmd.load   = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // The update waits until the output register can take the result.
        cmd.commit = !sts.out_valid || out_tready;
        if (cmd.commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ksa_datapath.sv =====
`default_nettype none

module ksa_datapath #(
  parameter int SLOTS    = 64,
  parameter int KEY_BITS = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire ksa_pkg::ksa_cmd_t                 cmd,
  output ksa_pkg::ksa_sts_t                      sts,
  input  wire logic [ksa_pkg::KEY_FIELD_W-1:0]   in_key,
  input  wire logic [ksa_pkg::IN_USER_W-1:0]     in_user,
  input  wire logic                              out_tready,
  output logic [ksa_pkg::OUT_DATA_W-1:0]         out_word
);

  import ksa_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  // Slot table: one key register and one live bit per slot.
  logic [KEY_BITS-1:0] slot_key_r [SLOTS];
  logic [SLOTS-1:0]    live_r;
  logic [SLOTS-1:0]    live_nxt;
  logic [CW-1:0]       free_count_r;
  logic [CW-1:0]       free_count_nxt;
  logic [CW-1:0]       next_fresh_r;
  logic [CW-1:0]       next_fresh_nxt;

  // Captured request.
  logic [SLOTS-1:0]    match_nxt;
  logic [SLOTS-1:0]    match_r;
  logic [KEY_BITS-1:0] key_r;
  ksa_req_t            req_r;
  logic                has_obj_r;

  // Output register.
  logic                out_valid_r;
  logic [IW-1:0]       out_idx_r;
  logic                out_present_r;
  ksa_status_t         out_status_r;
  logic [CW-1:0]       out_count_r;

  // Free stack.
  logic [CW-1:0]       fc_dec;
  logic [IW-1:0]       stack_top;
  logic                push;

  // Decision.
  logic                hit;
  logic [IW-1:0]       hit_idx;
  logic                alloc;
  logic [IW-1:0]       alloc_idx;
  logic                release_hit;
  logic [IW-1:0]       res_idx;
  logic                res_present;
  ksa_status_t         res_status;

  logic [IW+IDX_FIELD_W-1:0] idx_ext;
  logic [CW+CNT_FIELD_W-1:0] cnt_ext;

  assign fc_dec = free_count_r - CW'(1);

  ksa_ram #(
    .WIDTH (IW),
    .DEPTH (SLOTS)
  ) u_free_stack (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (free_count_r[IW-1:0]),
    .wr_data (hit_idx),
    .rd_en   (cmd.lookup),
    .rd_addr (fc_dec[IW-1:0]),
    .rd_data (stack_top)
  );

  // Every slot compares against the incoming key in the accept cycle.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match_nxt[i] = live_r[i] && (slot_key_r[i] == in_key[KEY_BITS-1:0]);
    end
  end

  // At most one slot matches, so an OR of the matching indices encodes it.
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (match_r[i]) begin
        hit_idx = hit_idx | IW'(i);
      end
    end
  end

  assign hit = |match_r;

  always_comb begin
    alloc          = 1'b0;
    alloc_idx      = '0;
    release_hit    = 1'b0;
    push           = 1'b0;
    res_idx        = '0;
    res_present    = 1'b0;
    res_status     = ST_OK;
    free_count_nxt = free_count_r;
    next_fresh_nxt = next_fresh_r;
    if (req_r == REQ_ACQUIRE) begin
      if (!has_obj_r) begin
        res_status = ST_OK;
      end else if (hit) begin
        res_idx     = hit_idx;
        res_present = 1'b1;
      end else if (free_count_r != '0) begin
        alloc          = 1'b1;
        alloc_idx      = stack_top;
        res_idx        = stack_top;
        free_count_nxt = fc_dec;
      end else if (next_fresh_r < CW'(SLOTS)) begin
        alloc          = 1'b1;
        alloc_idx      = next_fresh_r[IW-1:0];
        res_idx        = next_fresh_r[IW-1:0];
        next_fresh_nxt = next_fresh_r + CW'(1);
      end else begin
        res_status = ST_FULL;
      end
    end else begin
      if (!hit) begin
        res_status = ST_ABSENT;
      end else begin
        release_hit = 1'b1;
        res_idx     = hit_idx;
        res_present = 1'b1;
        if (free_count_r < CW'(SLOTS)) begin
          push           = cmd.commit;
          free_count_nxt = free_count_r + CW'(1);
        end
      end
    end
  end

  always_comb begin
    live_nxt = live_r;
    if (alloc) begin
      live_nxt[alloc_idx] = 1'b1;
    end
    if (release_hit) begin
      live_nxt[hit_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r       <= '0;
      free_count_r <= '0;
      next_fresh_r <= '0;
      match_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        match_r <= match_nxt;
      end
      if (cmd.commit) begin
        live_r       <= live_nxt;
        free_count_r <= free_count_nxt;
        next_fresh_r <= next_fresh_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r     <= in_key[KEY_BITS-1:0];
      req_r     <= ksa_req_t'(in_user[0]);
      has_obj_r <= in_user[1];
    end
    if (cmd.commit && alloc) begin
      slot_key_r[alloc_idx] <= key_r;
    end
    if (cmd.commit) begin
      out_idx_r     <= res_idx;
      out_present_r <= res_present;
      out_status_r  <= res_status;
      out_count_r   <= next_fresh_nxt;
    end
  end

  // Widen then cut to the fixed field widths: small values are zero-padded, large ones truncated.
  assign idx_ext = {{IDX_FIELD_W{1'b0}}, out_idx_r};
  assign cnt_ext = {{CNT_FIELD_W{1'b0}}, out_count_r};

  assign out_word = {cnt_ext[CNT_FIELD_W-1:0], out_status_r, out_present_r,
                     idx_ext[IDX_FIELD_W-1:0]};

  assign sts.out_valid = out_valid_r;

  // Each index handed out is either live or waiting on the free stack.
  a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(live_r) + 32'(free_count_r)) == 32'(next_fresh_r))
    else $error("live slots plus free entries differ from indices handed out");

  a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_r))
    else $error("key is live in more than one slot");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && res_status == ST_FULL) |->
      (free_count_r == '0 && next_fresh_r == CW'(SLOTS)))
    else $error("table reported full while an index was still available");

  a_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> next_fresh_r >= $past(next_fresh_r))
    else $error("high-water count went down");

endmodule

`default_nettype wire

// ===== hw/rtl/keyed_slot_allocator.sv =====
`default_nettype none

// Channel   Direction  Ports                        Word
// in        slave      in_tvalid/tready/tdata/tuser one acquire or release request
// out       master     out_tvalid/tready/tdata      one result per request
//
// In the accept cycle the key is compared against every slot in parallel and the
// top of the free stack is read; the update state then encodes the match and
// updates the slot table, stack and counters.
// Reset clears the live bits and counters; keys and stack need no clearing pass.
// A result waits in the output register while out_tready is low; one further
// request is accepted meanwhile and holds in its update state.

module keyed_slot_allocator #(
  parameter int SLOTS    = 64,
  parameter int KEY_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // key
  input  wire logic [1:0]  in_tuser,   // req_type, has_object
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // slot_index, was_present, status, allocated_count
);

  import ksa_pkg::*;

  ksa_cmd_t cmd;
  ksa_sts_t sts;

  ksa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ksa_datapath #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_key     (in_tdata),
    .in_user    (in_tuser),
    .out_tready (out_tready),
    .out_word   (out_tdata)
  );

  assign out_tvalid = sts.out_valid;

endmodule

`default_nettype wire
